// ===== hdl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants, codes and character classes of the token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MaxToken = 32;
  localparam int CntW     = $clog2(MaxToken + 1);
  localparam int AddrW    = $clog2(MaxToken);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_COMMENT = 4'd1;
  localparam logic [3:0] ST_CHARLIT = 4'd2;
  localparam logic [3:0] ST_MINUS   = 4'd3;
  localparam logic [3:0] ST_INT     = 4'd4;
  localparam logic [3:0] ST_DOT     = 4'd5;
  localparam logic [3:0] ST_FRAC    = 4'd6;
  localparam logic [3:0] ST_IDENT   = 4'd7;
  localparam logic [3:0] ST_STRING  = 4'd8;
  localparam logic [3:0] ST_STRESC  = 4'd9;

  localparam logic [2:0] K_IDENT  = 3'd0;
  localparam logic [2:0] K_INT    = 3'd1;
  localparam logic [2:0] K_DEC    = 3'd2;
  localparam logic [2:0] K_STRING = 3'd3;
  localparam logic [2:0] K_CHAR   = 3'd4;
  localparam logic [2:0] K_SINGLE = 3'd5;
  localparam logic [2:0] K_END    = 3'd6;
  localparam logic [2:0] K_BIG    = 3'd7;

  localparam logic [2:0] RegBigNumber = 3'd0;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0c) || (c == 8'h09) || (c == 8'h0b) ||
           (c == 8'h0d);
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_") || (c == "-") || (c == "+") ||
           (c == "*") || (c == "/") || (c == "%") || (c == "<") || (c == ">") ||
           (c == "=") || (c == "&");
  endfunction

  function automatic logic is_start(input logic [7:0] c);
    return is_alpha(c) || (c == "_") || (c == "+") || (c == "*") || (c == "/") ||
           (c == "%") || (c == "<") || (c == ">") || (c == "=") || (c == "&") ||
           (c == "$") || (c == ":") || (c == "^") || (c == "#") || (c == 8'h5c) ||
           (c == "@") || (c == "~") || (c == "|");
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      "a":     r = 8'd7;
      "b":     r = 8'd8;
      "f":     r = 8'd12;
      "n":     r = 8'd10;
      "r":     r = 8'd13;
      "t":     r = 8'd9;
      "v":     r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/lts_if.sv =====
// ----------------------------------------------------------------------------
// lts_in_if / lts_out_if
// Valid/ready channels for source bytes and token result beats.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  token_byte;
  logic        last_byte;
  logic [5:0]  token_length;
  logic        overflowed;
  logic [15:0] line_number;
  modport source (output valid, token_kind, token_byte, last_byte, token_length,
                  overflowed, line_number, input ready);
  modport sink (input valid, token_kind, token_byte, last_byte, token_length,
                overflowed, line_number, output ready);
endinterface

// ===== hdl/lts_ram.sv =====
// ----------------------------------------------------------------------------
// lts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lts_core.sv =====
// ----------------------------------------------------------------------------
// lts_core
// Scan sequencer: steps one byte through the scanner, writes token text to
// the store and reads it back as a run of result beats.
// ----------------------------------------------------------------------------
module lts_core
  import lts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             big_number_i,
  lts_in_if.sink           in_i,
  lts_out_if.source        out_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i
);

  localparam logic [2:0] F_ACC   = 3'd0;
  localparam logic [2:0] F_STEP  = 3'd1;
  localparam logic [2:0] F_ERD   = 3'd2;
  localparam logic [2:0] F_EOUT  = 3'd3;
  localparam logic [2:0] F_EZERO = 3'd4;
  localparam logic [2:0] F_FIN   = 3'd5;

  logic [2:0]      fsm_q, fsm_d, ret_q, ret_d;
  logic [3:0]      st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic            trunc_q, trunc_d;
  logic [15:0]     line_q, line_d;
  logic [7:0]      c_q;
  logic            eoi_q;
  logic [2:0]      kind_q, kind_d;

  logic        ovalid_q, ovalid_d, oload, out_free;
  logic [7:0]  obyte_d, obyte_q;
  logic        olast_d, olast_q;
  logic [2:0]  okind_q;
  logic [5:0]  olen_q;
  logic        otrunc_q;
  logic [15:0] oline_q;

  logic [3:0]      nst;
  logic            rescan, clr, app, emit, lninc;
  logic [7:0]      av;
  logic [2:0]      ek;
  logic [CntW-1:0] base;
  logic            tbase;
  logic            accept;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (fsm_q == F_ACC);
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    nst = st_q; rescan = 1'b0; clr = 1'b0; app = 1'b0; av = c_q;
    emit = 1'b0; ek = K_IDENT; lninc = 1'b0;
    if (eoi_q) begin
      nst = ST_IDLE;
      unique case (st_q)
        ST_CHARLIT:            begin clr = 1'b1; emit = 1'b1; ek = K_CHAR; end
        ST_MINUS, ST_IDENT:    begin emit = 1'b1; ek = K_IDENT; end
        ST_INT:                begin emit = 1'b1; ek = big_number_i ? K_BIG : K_INT; end
        ST_FRAC:               begin emit = 1'b1; ek = big_number_i ? K_BIG : K_DEC; end
        ST_STRING, ST_STRESC:  begin emit = 1'b1; ek = K_STRING; end
        default:               ;
      endcase
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          clr = 1'b1;
          priority if (c_q == 8'h0a) lninc = 1'b1;
          else if (is_ws(c_q)) ;
          else if (c_q == ";") nst = ST_COMMENT;
          else if (c_q == "?") nst = ST_CHARLIT;
          else if (c_q == "-") begin app = 1'b1; nst = ST_MINUS; end
          else if (is_digit(c_q)) begin app = 1'b1; nst = ST_INT; end
          else if (is_start(c_q)) begin app = 1'b1; nst = ST_IDENT; end
          else if (c_q == 8'h22) nst = ST_STRING;
          else begin app = 1'b1; emit = 1'b1; ek = K_SINGLE; end
        end
        ST_COMMENT: if (c_q == 8'h0a) begin lninc = 1'b1; nst = ST_IDLE; end
        ST_CHARLIT: begin
          clr = 1'b1; app = 1'b1; emit = 1'b1; ek = K_CHAR; nst = ST_IDLE;
        end
        ST_MINUS: begin nst = is_digit(c_q) ? ST_INT : ST_IDENT; rescan = 1'b1; end
        ST_INT: begin
          priority if (is_digit(c_q)) app = 1'b1;
          else if (c_q == ".") begin app = 1'b1; nst = ST_DOT; end
          else if (is_alpha(c_q)) begin clr = 1'b1; nst = ST_IDLE; rescan = 1'b1; end
          else begin
            emit = 1'b1; ek = big_number_i ? K_BIG : K_INT; nst = ST_IDLE; rescan = 1'b1;
          end
        end
        ST_DOT: begin
          if (is_digit(c_q)) begin app = 1'b1; nst = ST_FRAC; end
          else begin clr = 1'b1; nst = ST_IDLE; rescan = 1'b1; end
        end
        ST_FRAC: begin
          if (is_digit(c_q)) app = 1'b1;
          else begin
            emit = 1'b1; ek = big_number_i ? K_BIG : K_DEC; nst = ST_IDLE; rescan = 1'b1;
          end
        end
        ST_IDENT: begin
          if (is_cont(c_q)) app = 1'b1;
          else begin emit = 1'b1; ek = K_IDENT; nst = ST_IDLE; rescan = 1'b1; end
        end
        ST_STRING: begin
          priority if (c_q == 8'h22) begin emit = 1'b1; ek = K_STRING; nst = ST_IDLE; end
          else if (c_q == 8'h5c) nst = ST_STRESC;
          else begin lninc = (c_q == 8'h0a); app = 1'b1; end
        end
        ST_STRESC: begin
          if (c_q == 8'h0a) lninc = 1'b1;
          else begin app = 1'b1; av = esc_code(c_q); end
          nst = ST_STRING;
        end
        default: begin nst = ST_IDLE; rescan = 1'b1; end
      endcase
    end
    base  = clr ? '0 : cnt_q;
    tbase = clr ? 1'b0 : trunc_q;
  end

  always_comb begin
    fsm_d = fsm_q; ret_d = ret_q; st_d = st_q; cnt_d = cnt_q; idx_d = idx_q;
    trunc_d = trunc_q; line_d = line_q; kind_d = kind_q;
    ram_we_o = 1'b0; ram_waddr_o = base[AddrW-1:0]; ram_wdata_o = av;
    ram_re_o = 1'b0; ram_raddr_o = idx_q[AddrW-1:0];
    oload = 1'b0; obyte_d = ram_rdata_i; olast_d = 1'b0;
    unique case (fsm_q)
      F_ACC: if (accept) fsm_d = F_STEP;
      F_STEP: begin
        st_d = nst; cnt_d = base; trunc_d = tbase; kind_d = ek;
        if (lninc) line_d = line_q + 16'd1;
        if (app) begin
          if (base < CntW'(MaxToken)) begin
            ram_we_o = 1'b1;
            cnt_d = base + CntW'(1);
          end else begin
            trunc_d = 1'b1;
          end
        end
        idx_d = '0;
        if (eoi_q) begin
          ret_d = F_FIN;
          fsm_d = emit ? ((cnt_d == '0) ? F_EZERO : F_ERD) : F_FIN;
        end else if (emit) begin
          ret_d = rescan ? F_STEP : F_ACC;
          fsm_d = (cnt_d == '0) ? F_EZERO : F_ERD;
        end else begin
          fsm_d = rescan ? F_STEP : F_ACC;
        end
      end
      F_ERD: begin ram_re_o = 1'b1; fsm_d = F_EOUT; end
      F_EOUT: if (out_free) begin
        oload = 1'b1;
        olast_d = (idx_q + CntW'(1) == cnt_q);
        idx_d = idx_q + CntW'(1);
        if (olast_d) begin
          cnt_d = '0; trunc_d = 1'b0; fsm_d = ret_q;
        end else begin
          fsm_d = F_ERD;
        end
      end
      F_EZERO: if (out_free) begin
        oload = 1'b1; obyte_d = 8'd0; olast_d = 1'b1;
        cnt_d = '0; trunc_d = 1'b0; fsm_d = ret_q;
      end
      F_FIN: begin
        kind_d = K_END; cnt_d = '0; trunc_d = 1'b0; ret_d = F_ACC; fsm_d = F_EZERO;
      end
      default: fsm_d = F_ACC;
    endcase
    ovalid_d = oload ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= F_ACC; ret_q <= F_ACC; st_q <= ST_IDLE; cnt_q <= '0; idx_q <= '0;
      trunc_q <= 1'b0; line_q <= 16'd1; ovalid_q <= 1'b0; kind_q <= K_IDENT;
    end else begin
      fsm_q <= fsm_d; ret_q <= ret_d; st_q <= st_d; cnt_q <= cnt_d; idx_q <= idx_d;
      trunc_q <= trunc_d; line_q <= line_d; ovalid_q <= ovalid_d; kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q <= in_i.in_byte; eoi_q <= in_i.end_of_input;
    end
    if (oload) begin
      obyte_q <= obyte_d; olast_q <= olast_d; okind_q <= kind_q;
      olen_q <= 6'(cnt_q); otrunc_q <= trunc_q; oline_q <= line_q;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.token_kind   = okind_q;
  assign out_o.token_byte   = obyte_q;
  assign out_o.last_byte    = olast_q;
  assign out_o.token_length = olen_q;
  assign out_o.overflowed   = otrunc_q;
  assign out_o.line_number  = oline_q;

endmodule

// ===== hdl/lisp_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// lisp_token_scanner_unit
// Lisp token scanner with a 32-byte text store and an APB mode register.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is stepped through the scanner, again per rescan;
// no new byte is taken until it and its token run are done. A token run
// reads each stored text byte from the store, then loads it into the output
// (one zero beat for an empty token); output back-pressure stalls the run.
// Reset: scanner idle, line count 1, mode 0; the text store is not cleared.
module lisp_token_scanner_unit
  import lts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lts_in_if.sink      in_i,
  lts_out_if.source   out_o
);

  logic             big_q;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == RegBigNumber) ? {31'd0, big_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == RegBigNumber)) begin
      big_q <= pwdata[0];
    end
  end

  lts_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .big_number_i (big_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .ram_we_o     (we),
    .ram_waddr_o  (waddr),
    .ram_wdata_o  (wdata),
    .ram_re_o     (re),
    .ram_raddr_o  (raddr),
    .ram_rdata_i  (rdata)
  );

  lts_ram #(.Width(8), .Depth(MaxToken)) u_text (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== tb/lts_token_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lts_token_checker
// Watches the source-byte and token channels of the scanner, predicts every
// token beat from each accepted source beat and compares them field by field.
// ----------------------------------------------------------------------------
module lts_token_checker
  import lts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic big_mode_i,
  lts_in_if    in_ch,
  lts_out_if   out_ch,
  output int   errors_o,
  output int   pending_o,
  output int   tokens_o
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tbyte;
    logic        last;
    logic [5:0]  len;
    logic        ovf;
    logic [15:0] line;
  } token_beat_t;

  token_beat_t beat_q[$];

  logic [3:0]  scan_st;
  logic [7:0]  text_mem[MaxToken];
  int          text_len;
  logic        text_cut;
  logic [15:0] line_cnt;
  logic        num_big;

  function automatic bit chr_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit chr_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit chr_in(string s, logic [7:0] c);
    for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1;
    return 0;
  endfunction

  function automatic bit chr_cont(logic [7:0] c);
    return chr_alpha(c) || chr_digit(c) || chr_in("_-+*/%<>=&", c);
  endfunction

  function automatic bit chr_start(logic [7:0] c);
    return chr_alpha(c) || chr_in("_+*/%<>=&$:^#\\@~|", c);
  endfunction

  function automatic logic [7:0] escape_byte(logic [7:0] c);
    case (c)
      "a":     return 8'd7;
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "v":     return 8'd11;
      default: return c;
    endcase
  endfunction

  function automatic void line_step();
    line_cnt = line_cnt + 16'd1;
  endfunction

  function automatic void text_clear();
    text_len = 0;
    text_cut = 1'b0;
  endfunction

  function automatic void text_add(logic [7:0] c);
    if (text_len < MaxToken) begin
      text_mem[text_len] = c;
      text_len++;
    end else begin
      text_cut = 1'b1;
    end
  endfunction

  function automatic void post_beat(logic [2:0] kind, logic [7:0] b, logic last);
    token_beat_t t;
    t.kind  = kind;
    t.tbyte = b;
    t.last  = last;
    t.len   = 6'(text_len);
    t.ovf   = text_cut;
    t.line  = line_cnt;
    beat_q.push_back(t);
  endfunction

  function automatic void emit_token(logic [2:0] kind);
    if (text_len == 0) begin
      post_beat(kind, 8'd0, 1'b1);
    end else begin
      for (int i = 0; i < text_len; i++) post_beat(kind, text_mem[i], i + 1 == text_len);
    end
    text_clear();
  endfunction

  function automatic logic [2:0] number_kind(bit dec);
    if (num_big) return K_BIG;
    return dec ? K_DEC : K_INT;
  endfunction

  // returns 1 when the byte must be scanned again
  function automatic bit scan_char(logic [7:0] c);
    case (scan_st)
      ST_IDLE: begin
        text_clear();
        if (c == 8'h0a) line_step();
        else if (c == " " || c == 8'h0c || c == 8'h09 || c == 8'h0b || c == 8'h0d) begin
        end else if (c == ";") scan_st = ST_COMMENT;
        else if (c == "?") scan_st = ST_CHARLIT;
        else if (c == "-") begin
          text_add(c);
          scan_st = ST_MINUS;
        end else if (chr_digit(c)) begin
          text_add(c);
          scan_st = ST_INT;
        end else if (chr_start(c)) begin
          text_add(c);
          scan_st = ST_IDENT;
        end else if (c == "\"") scan_st = ST_STRING;
        else begin
          text_add(c);
          emit_token(K_SINGLE);
        end
        return 0;
      end
      ST_COMMENT: begin
        if (c == 8'h0a) begin
          line_step();
          scan_st = ST_IDLE;
        end
        return 0;
      end
      ST_CHARLIT: begin
        text_clear();
        text_add(c);
        emit_token(K_CHAR);
        scan_st = ST_IDLE;
        return 0;
      end
      ST_MINUS: begin
        scan_st = chr_digit(c) ? ST_INT : ST_IDENT;
        return 1;
      end
      ST_INT: begin
        if (chr_digit(c)) begin
          text_add(c);
          return 0;
        end
        if (c == ".") begin
          text_add(c);
          scan_st = ST_DOT;
          return 0;
        end
        if (chr_alpha(c)) text_clear();
        else emit_token(number_kind(0));
        scan_st = ST_IDLE;
        return 1;
      end
      ST_DOT: begin
        if (chr_digit(c)) begin
          text_add(c);
          scan_st = ST_FRAC;
          return 0;
        end
        text_clear();
        scan_st = ST_IDLE;
        return 1;
      end
      ST_FRAC: begin
        if (chr_digit(c)) begin
          text_add(c);
          return 0;
        end
        emit_token(number_kind(1));
        scan_st = ST_IDLE;
        return 1;
      end
      ST_IDENT: begin
        if (chr_cont(c)) begin
          text_add(c);
          return 0;
        end
        emit_token(K_IDENT);
        scan_st = ST_IDLE;
        return 1;
      end
      ST_STRING: begin
        if (c == "\"") begin
          emit_token(K_STRING);
          scan_st = ST_IDLE;
        end else if (c == 8'h5c) scan_st = ST_STRESC;
        else begin
          if (c == 8'h0a) line_step();
          text_add(c);
        end
        return 0;
      end
      ST_STRESC: begin
        if (c == 8'h0a) line_step();
        else text_add(escape_byte(c));
        scan_st = ST_STRING;
        return 0;
      end
      default: begin
        scan_st = ST_IDLE;
        return 1;
      end
    endcase
  endfunction

  function automatic void close_source();
    case (scan_st)
      ST_CHARLIT: begin
        text_clear();
        emit_token(K_CHAR);
      end
      ST_MINUS, ST_IDENT: emit_token(K_IDENT);
      ST_INT:             emit_token(number_kind(0));
      ST_FRAC:            emit_token(number_kind(1));
      ST_STRING, ST_STRESC: emit_token(K_STRING);
      default: ;
    endcase
    text_clear();
    emit_token(K_END);
    scan_st = ST_IDLE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_beat_t exp_b;
    token_beat_t got_b;
    if (!rst_ni) begin
      beat_q.delete();
      scan_st   = ST_IDLE;
      text_len  = 0;
      text_cut  = 1'b0;
      line_cnt  = 16'd1;
      errors_o  = 0;
      pending_o = 0;
      tokens_o  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        num_big = big_mode_i;
        if (in_ch.end_of_input) close_source();
        else while (scan_char(in_ch.in_byte)) ;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_b = '{out_ch.token_kind, out_ch.token_byte, out_ch.last_byte,
                  out_ch.token_length, out_ch.overflowed, out_ch.line_number};
        if (beat_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected token beat %h", $time, got_b);
        end else begin
          exp_b = beat_q.pop_front();
          if (got_b.last) tokens_o++;
          if (exp_b != got_b) begin
            errors_o++;
            $display("%0t: token beat mismatch", $time);
            if (exp_b.kind != got_b.kind)
              $display("%0t:   kind exp %0d got %0d", $time, exp_b.kind, got_b.kind);
            if (exp_b.tbyte != got_b.tbyte)
              $display("%0t:   byte exp %h got %h", $time, exp_b.tbyte, got_b.tbyte);
            if (exp_b.last != got_b.last)
              $display("%0t:   last exp %0d got %0d", $time, exp_b.last, got_b.last);
            if (exp_b.len != got_b.len)
              $display("%0t:   length exp %0d got %0d", $time, exp_b.len, got_b.len);
            if (exp_b.ovf != got_b.ovf)
              $display("%0t:   overflow exp %0d got %0d", $time, exp_b.ovf, got_b.ovf);
            if (exp_b.line != got_b.line)
              $display("%0t:   line exp %0d got %0d", $time, exp_b.line, got_b.line);
          end
        end
      end
      pending_o = beat_q.size();
    end
  end

endmodule

// ===== tb/lisp_token_scanner_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lisp_token_scanner_unit_tb
// Feeds directed and random Lisp source text to the token scanner under
// random stalls on both channels and mode register changes; a checker
// module predicts and compares every token beat.
// ----------------------------------------------------------------------------
module lisp_token_scanner_unit_tb;
  import lts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        big_mode;

  int errors;
  int pending;
  int tokens;
  int snd_gap;
  int rcv_stall;
  int sent;
  int hold_at;
  bit hold_req;
  logic [8:0] src_q[$];

  lts_in_if  in_ch ();
  lts_out_if out_ch ();

  lisp_token_scanner_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  lts_token_checker checker_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .big_mode_i (big_mode),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .errors_o   (errors),
    .pending_o  (pending),
    .tokens_o   (tokens)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (250) @(posedge clk_i);
        hold_req = 0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 4000) begin
        $display("lisp_token_scanner_unit_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= RegBigNumber << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    big_mode <= value[0];
  endtask

  task automatic send_beat(logic [8:0] b);
    bit rdy;
    if ($urandom_range(0, 99) < snd_gap) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b[7:0];
    in_ch.end_of_input <= b[8];
    do begin
      @(negedge clk_i);
      rdy = in_ch.ready;
      @(posedge clk_i);
    end while (!rdy);
    sent++;
    if (sent == hold_at) hold_req = 1;
  endtask

  task automatic drain_source();
    while (src_q.size() > 0) send_beat(src_q.pop_front());
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
  endtask

  task automatic add_byte(logic [7:0] b);
    src_q.push_back({1'b0, b});
  endtask

  task automatic add_end();
    src_q.push_back(9'h100);
  endtask

  task automatic add_digits(int n);
    repeat (n) add_byte(8'($urandom_range("0", "9")));
  endtask

  task automatic add_alpha();
    add_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z")));
  endtask

  task automatic add_random_token();
    string starts;
    string conts;
    string escs;
    string seps;
    int    n;
    starts = "_+*/%<>=&$:^#\\@~|";
    conts  = "_-+*/%<>=&";
    escs   = "abfnrtvq\"\\\n";
    seps   = " \n()\t'";
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1)) add_alpha();
        else add_byte(starts[$urandom_range(0, starts.len() - 1)]);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 40) : $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: add_alpha();
            1: add_digits(1);
            default: add_byte(conts[$urandom_range(0, conts.len() - 1)]);
          endcase
        end
      end
      2, 3: begin
        if ($urandom_range(0, 2) == 0) add_text("-");
        add_digits(($urandom_range(0, 19) == 0) ? $urandom_range(31, 36) : $urandom_range(1, 4));
        case ($urandom_range(0, 4))
          0: begin
            add_text(".");
            add_digits($urandom_range(1, 3));
          end
          1: add_alpha();
          2: begin
            add_text(".");
            add_byte($urandom_range(0, 1) ? "x" : " ");
          end
          default: ;
        endcase
      end
      4: begin
        add_text("\"");
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0: begin
              add_byte(8'h5c);
              add_byte(escs[$urandom_range(0, escs.len() - 1)]);
            end
            1: add_text("\n");
            default: begin
              n = $urandom_range(0, 255);
              if (n == "\"" || n == 8'h5c) n = "s";
              add_byte(8'(n));
            end
          endcase
        end
        add_text("\"");
      end
      5: begin
        add_text("?");
        add_byte(8'($urandom_range(0, 255)));
      end
      6: begin
        add_text(";");
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(32, 126)));
        add_text("\n");
      end
      7: add_byte(8'($urandom_range(0, 255)));
      8: add_byte(seps[$urandom_range(0, seps.len() - 1)]);
      default: if ($urandom_range(0, 3) == 0) add_end();
    endcase
    if ($urandom_range(0, 2) != 0) add_byte(seps[$urandom_range(0, seps.len() - 1)]);
  endtask

  task automatic random_phase(int beats);
    int goal;
    goal = sent + beats;
    while (sent < goal) begin
      add_random_token();
      drain_source();
    end
    add_end();
    drain_source();
    wait_quiet();
  endtask

  initial begin
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    big_mode           <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= '0;
    in_ch.end_of_input <= 1'b0;
    snd_gap   = 33;
    rcv_stall = 55;
    sent      = 0;
    hold_at   = -1;
    hold_req  = 0;
    rst_ni    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    add_text("a -5 - 12x 3.z 3.14 12. ");
    add_text("abcdefghijklmnopqrstuvwxyz0123456789XY ");
    add_text("\"a\\n\\t\\v\\f\\r\\b\\a\\q\\\nb\n\" ?\n?x (");
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h80);
    add_text("ab");
    add_byte(8'h00);
    add_text(" ;open comment");
    add_end();
    add_text("?");
    add_end();
    add_text("12.");
    add_end();
    add_text("\"open\\");
    add_end();
    add_text("-");
    add_end();
    add_text("7.25");
    add_end();
    drain_source();
    wait_quiet();

    reg_write(32'd1);
    hold_at = sent + 60;
    add_text("42 1.5 ");
    random_phase(90);

    reg_write(32'd0);
    snd_gap   = 55;
    rcv_stall = 33;
    random_phase(90);

    reg_write(32'd1);
    snd_gap   = 0;
    rcv_stall = 0;
    random_phase(80);

    $display("covered %0d source beats and %0d tokens, both number modes,", sent, tokens);
    $display("overlong text, broken numbers and open tokens at end of input");
    if (errors == 0 && pending == 0) begin
      $display("lisp_token_scanner_unit_tb: done, clean");
    end else begin
      $display("lisp_token_scanner_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
